/* src/cths_pkg.sv */
// Package for the crypt table string hash: fixed constants, the mixing table
// type and the elaboration-time generator that fills the mixing table.
// No dependencies.
`timescale 1ns / 1ps

package cths_pkg;

	localparam int unsigned TABLE_BLOCKS = 5;
	localparam int unsigned BLOCK_WORDS  = 256;

	localparam logic [31:0] SEED_ONE_INIT = 32'h7FED7FED;
	localparam logic [31:0] SEED_TWO_INIT = 32'hEEEEEEEE;
	localparam logic [31:0] SEED_TWO_INC  = 32'd3;

	localparam logic [31:0] GEN_START = 32'h00100001;
	localparam logic [31:0] GEN_MULT  = 32'd125;
	localparam logic [31:0] GEN_INC   = 32'd3;
	localparam logic [31:0] GEN_MOD   = 32'h002AAAAB;

	// ASCII lower-case range
	localparam logic [7:0] LOWER_A = 8'h61;
	localparam logic [7:0] LOWER_Z = 8'h7A;
	localparam logic [7:0] CASE_OFFSET = 8'h20;

	typedef logic [BLOCK_WORDS-1:0][31:0] blk_words_t;
	typedef logic [TABLE_BLOCKS-1:0][BLOCK_WORDS-1:0][31:0] mix_table_t;

	// Runs the congruential generator once at elaboration; per column,
	// each block takes two draws (high half, then low half).
	function automatic mix_table_t gen_table();
		mix_table_t  tbl;
		logic [31:0] s;
		logic [15:0] hi;
		logic [15:0] lo;
		s = GEN_START;
		tbl = '0;
		for (int col = 0; col < BLOCK_WORDS; col++) begin
			for (int blk = 0; blk < TABLE_BLOCKS; blk++) begin
				s = (s * GEN_MULT + GEN_INC) % GEN_MOD;
				hi = s[15:0];
				s = (s * GEN_MULT + GEN_INC) % GEN_MOD;
				lo = s[15:0];
				tbl[blk][col] = {hi, lo};
			end
		end
		return tbl;
	endfunction

	localparam mix_table_t MIX_TABLE = gen_table();

endpackage

/* src/crypt_table_string_hash.sv */
// Top level of the crypt table string hash: input register, table read stage
// and seed update with result register.
// Depends on cths_pkg (constants and the generated mixing table).
`timescale 1ns / 1ps

// Hashes a key streamed one byte per request, taking one byte every cycle
// unless stalled. A key is any run of bytes ending with last_byte set;
// hash_type picks one of five 256-word blocks of a fixed mixing table (types
// above four read zero). Lower-case ASCII letters are folded to upper case
// before hashing. The last accepted byte is loaded into the input register,
// its table word is registered next, and the seed update then loads the
// hash into the result register. The seed update is the loop that sets the
// one-byte-per-cycle rate. The seeds return to their start values after
// each key, so keys follow each other with no gap. The pipeline stalls only
// while a finished hash is held and out_ready is low.
module crypt_table_string_hash (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [7:0]  key_byte,
	input  logic [2:0]  hash_type,
	input  logic        last_byte,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [31:0] hash_value
);

	logic        adv;
	logic        valid_s1, valid_s2;
	logic [7:0]  chr_s1, chr_s2;
	logic [2:0]  htype_s1;
	logic        last_s1, last_s2;
	logic [31:0] word_s2;
	logic [31:0] seed_one_q, seed_two_q;
	logic [31:0] hash_q;
	logic        out_valid_q;
	logic [7:0]  chr_up;
	logic [31:0] blk_word [cths_pkg::TABLE_BLOCKS];
	logic [31:0] word_sel;
	logic [31:0] seed_one_nx, seed_two_nx;

	// whole pipeline moves unless a held hash is not being taken
	assign adv      = !out_valid_q || out_ready;
	assign in_ready = adv;

	// upper-case fold of the incoming byte
	always_comb begin
		if (key_byte >= cths_pkg::LOWER_A && key_byte <= cths_pkg::LOWER_Z) begin
			chr_up = key_byte - cths_pkg::CASE_OFFSET;
		end else begin
			chr_up = key_byte;
		end
	end

	// stage 1: input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (adv) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			chr_s1   <= chr_up;
			htype_s1 <= hash_type;
			last_s1  <= last_byte;
		end
	end

	// table read: one word from each block, then pick by hash type
	always_comb begin
		for (int b = 0; b < cths_pkg::TABLE_BLOCKS; b++) begin
			blk_word[b] = cths_pkg::MIX_TABLE[b][chr_s1];
		end
	end

	always_comb begin
		if (htype_s1 < 3'(cths_pkg::TABLE_BLOCKS)) begin
			word_sel = blk_word[htype_s1];
		end else begin
			word_sel = '0;
		end
	end

	// stage 2: registered table word
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (adv) begin
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			chr_s2  <= chr_s1;
			last_s2 <= last_s1;
			word_s2 <= word_sel;
		end
	end

	// seed recurrence, modulo 2^32
	assign seed_one_nx = word_s2 ^ (seed_one_q + seed_two_q);
	assign seed_two_nx = {24'd0, chr_s2} + seed_one_nx + seed_two_q
		+ {seed_two_q[26:0], 5'd0} + cths_pkg::SEED_TWO_INC;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			seed_one_q <= cths_pkg::SEED_ONE_INIT;
			seed_two_q <= cths_pkg::SEED_TWO_INIT;
		end else if (adv && valid_s2) begin
			if (last_s2) begin
				seed_one_q <= cths_pkg::SEED_ONE_INIT;
				seed_two_q <= cths_pkg::SEED_TWO_INIT;
			end else begin
				seed_one_q <= seed_one_nx;
				seed_two_q <= seed_two_nx;
			end
		end
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (adv) begin
			out_valid_q <= valid_s2 && last_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (adv && valid_s2 && last_s2) begin
			hash_q <= seed_one_nx;
		end
	end

	assign out_valid  = out_valid_q;
	assign hash_value = hash_q;

	// a finished key leaves the seeds at their start values
	a_seed_reload: assert property (@(posedge clk) disable iff (!arst_n)
		(adv && valid_s2 && last_s2) |=>
		(seed_one_q == cths_pkg::SEED_ONE_INIT && seed_two_q == cths_pkg::SEED_TWO_INIT))
		else $error("seeds not reloaded after last byte");

	// a new hash only follows a last byte in stage 2
	a_out_source: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid_q) |-> $past(valid_s2 && last_s2))
		else $error("result without a last byte");

	// while stalled the table stage and seeds hold
	a_stall_hold: assert property (@(posedge clk) disable iff (!arst_n)
		!adv |=> ($stable(word_s2) && $stable(seed_one_q) && $stable(seed_two_q)))
		else $error("pipeline moved during stall");

endmodule

/* dv/crypt_table_string_hash_tb.sv */
// Self-checking testbench for crypt_table_string_hash: streams key bytes,
// predicts each key hash and checks every hash the block returns.
// Depends only on the crypt_table_string_hash RTL (and its package).
`timescale 1ns / 1ps

module crypt_table_string_hash_tb;

	localparam logic [31:0] SEED_ONE_START = 32'h7FED7FED;
	localparam logic [31:0] SEED_TWO_START = 32'hEEEEEEEE;
	localparam logic [31:0] LCG_START      = 32'h00100001;
	localparam logic [31:0] LCG_MULT       = 32'd125;
	localparam logic [31:0] LCG_INC        = 32'd3;
	localparam logic [31:0] LCG_MOD        = 32'h002AAAAB;
	localparam int          MIX_BLOCKS     = 5;
	localparam int          MIX_WORDS      = 1280;
	localparam logic [7:0]  ASCII_LOW_A    = 8'h61;
	localparam logic [7:0]  ASCII_LOW_Z    = 8'h7A;
	localparam logic [7:0]  ASCII_CASE     = 8'h20;
	// single-byte key with a hash type past the table: 0 ^ (seed one + seed two)
	localparam logic [31:0] NO_TABLE_HASH  = 32'h6EDC6EDB;
	localparam int          RANDOM_BYTES   = 1550;
	localparam int          HOLD_CYCLES    = 200;
	localparam int          DRAIN_CYCLES   = 20;
	localparam int          DIRECTED_ROWS  = 22;

	typedef struct packed {
		logic [7:0]  key;
		logic [2:0]  htype;
		logic        lst;
		logic        known;
		logic [31:0] hash;
	} key_row_t;

	logic        clk = 1'b0;
	logic        arst_n;
	logic        in_valid;
	logic        in_ready;
	logic [7:0]  key_byte;
	logic [2:0]  hash_type;
	logic        last_byte;
	logic        out_valid;
	logic        out_ready;
	logic [31:0] hash_value;

	// predictor state
	logic [31:0] mix_words [0:MIX_WORDS-1];
	logic [31:0] seed_a;
	logic [31:0] seed_b;
	logic [31:0] pending_hashes [$];

	key_row_t    directed_rows [0:DIRECTED_ROWS-1];
	int          fail_count   = 0;
	int          hashes_seen  = 0;
	int          bytes_sent   = 0;
	int          send_gap_max = 9;
	int          recv_gap_max = 9;
	bit          hold_out     = 1'b0;

	crypt_table_string_hash uut (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_ready   (in_ready),
		.key_byte   (key_byte),
		.hash_type  (hash_type),
		.last_byte  (last_byte),
		.out_valid  (out_valid),
		.out_ready  (out_ready),
		.hash_value (hash_value)
	);

	// 4 ns clock
	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	// Fold one key byte into the predicted seeds; reports the hash on the last byte.
	task automatic absorb_key_byte(input logic [7:0] raw, input logic [2:0] htype,
			input logic lst, output logic done, output logic [31:0] hv);
		logic [7:0]  c;
		logic [10:0] addr;
		logic [31:0] word;
		c = (raw >= ASCII_LOW_A && raw <= ASCII_LOW_Z) ? raw - ASCII_CASE : raw;
		addr = {htype, c};
		word = (addr < MIX_WORDS) ? mix_words[addr] : 32'd0;
		seed_a = word ^ (seed_a + seed_b);
		seed_b = {24'd0, c} + seed_a + seed_b + (seed_b << 5) + 32'd3;
		done = lst;
		hv = seed_a;
		if (lst) begin
			seed_a = SEED_ONE_START;
			seed_b = SEED_TWO_START;
		end
	endtask

	// Offer one request after gap idle cycles; called and returns at a falling edge.
	task automatic send_byte(input logic [7:0] k, input logic [2:0] htype,
			input logic lst, input int gap, input logic known, input logic [31:0] hash);
		logic        done;
		logic [31:0] hv;
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		in_valid  <= 1'b1;
		key_byte  <= k;
		hash_type <= htype;
		last_byte <= lst;
		do @(posedge clk); while (!in_ready);
		absorb_key_byte(k, htype, lst, done, hv);
		if (done)
			pending_hashes.push_back(known ? hash : hv);
		bytes_sent++;
		@(negedge clk);
	endtask

	// Hold the sender until every expected hash has come back.
	task automatic drain_pause();
		in_valid <= 1'b0;
		wait (pending_hashes.size() == 0);
		@(negedge clk);
	endtask

	// One random key: mostly well-formed with a steady hash type, some noise.
	task automatic send_random_key(input int max_len);
		int         len;
		logic [2:0] htype;
		logic [7:0] k;
		bit         noisy;
		noisy = ($urandom_range(0, 99) < 15);
		len   = ($urandom_range(0, 99) < 80) ? $urandom_range(1, 6) : $urandom_range(7, 16);
		if (len > max_len)
			len = max_len;
		htype = 3'($urandom_range(0, 4));
		for (int i = 0; i < len; i++) begin
			if (noisy) begin
				htype = 3'($urandom_range(0, 7));
				k = 8'($urandom_range(0, 255));
			end else begin
				case ($urandom_range(0, 3))
					0: k = 8'(ASCII_LOW_A + $urandom_range(0, 25));
					1: k = 8'(8'h41 + $urandom_range(0, 25));
					2: k = 8'($urandom_range(8'h20, 8'h7E));
					default: k = 8'($urandom_range(1, 255));
				endcase
			end
			send_byte(k, htype, i == len - 1, $urandom_range(0, send_gap_max), 1'b0, 32'd0);
		end
	endtask

	// Result side: random stall per hash, plus one long hold on request.
	initial begin
		int stall;
		out_ready = 1'b0;
		wait (arst_n === 1'b1);
		@(negedge clk);
		forever begin
			if (hold_out) begin
				out_ready <= 1'b0;
				repeat (HOLD_CYCLES) @(negedge clk);
				hold_out = 1'b0;
			end
			stall = $urandom_range(0, recv_gap_max);
			if (stall > 0) begin
				out_ready <= 1'b0;
				repeat (stall) @(negedge clk);
			end
			out_ready <= 1'b1;
			do @(posedge clk); while (!out_valid);
			@(negedge clk);
		end
	end

	// Compare each returned hash with the oldest pending one
	always @(posedge clk) begin
		if (arst_n && out_valid && out_ready) begin
			if (pending_hashes.size() == 0) begin
				$error("hash_value: expected none pending, actual %08h", hash_value);
				fail_count++;
			end else begin
				if (hash_value !== pending_hashes[0]) begin
					$error("hash_value: expected %08h, actual %08h",
						pending_hashes[0], hash_value);
					fail_count++;
				end
				void'(pending_hashes.pop_front());
			end
			hashes_seen++;
		end
	end

	// Main sequence
	initial begin
		logic [31:0] s;
		in_valid  = 1'b0;
		key_byte  = 8'h00;
		hash_type = 3'd0;
		last_byte = 1'b0;
		arst_n    = 1'b0;

		// mixing table, column-major over the five blocks, two draws per word
		s = LCG_START;
		for (int col = 0; col < 256; col++) begin
			for (int blk = 0; blk < MIX_BLOCKS; blk++) begin
				s = (s * LCG_MULT + LCG_INC) % LCG_MOD;
				mix_words[blk * 256 + col][31:16] = s[15:0];
				s = (s * LCG_MULT + LCG_INC) % LCG_MOD;
				mix_words[blk * 256 + col][15:0] = s[15:0];
			end
		end
		seed_a = SEED_ONE_START;
		seed_b = SEED_TWO_START;

		// key, hash type, last, hash known, hash
		directed_rows = '{
			{8'hFF, 3'd7, 1'b1, 1'b1, NO_TABLE_HASH},  // right after reset, no table
			{8'h00, 3'd5, 1'b1, 1'b1, NO_TABLE_HASH},  // zero byte, no table
			{8'h01, 3'd0, 1'b1, 1'b0, 32'd0},
			{8'hFF, 3'd4, 1'b1, 1'b0, 32'd0},
			{8'h61, 3'd0, 1'b1, 1'b0, 32'd0},          // 'a' folds to 'A'
			{8'h41, 3'd0, 1'b1, 1'b0, 32'd0},
			{8'h7A, 3'd1, 1'b1, 1'b0, 32'd0},          // 'z'
			{8'h60, 3'd1, 1'b1, 1'b0, 32'd0},          // just below 'a'
			{8'h7B, 3'd2, 1'b1, 1'b0, 32'd0},          // just above 'z'
			{8'h61, 3'd3, 1'b0, 1'b0, 32'd0},          // "abc"
			{8'h62, 3'd3, 1'b0, 1'b0, 32'd0},
			{8'h63, 3'd3, 1'b1, 1'b0, 32'd0},
			{8'h41, 3'd0, 1'b0, 1'b0, 32'd0},          // hash type changes mid key
			{8'h42, 3'd6, 1'b0, 1'b0, 32'd0},
			{8'h43, 3'd2, 1'b1, 1'b0, 32'd0},
			{8'h00, 3'd1, 1'b0, 1'b0, 32'd0},          // zero byte inside a key
			{8'h80, 3'd1, 1'b1, 1'b0, 32'd0},
			{8'h55, 3'd6, 1'b1, 1'b1, NO_TABLE_HASH},
			{8'hAA, 3'd3, 1'b1, 1'b0, 32'd0},
			{8'h7F, 3'd4, 1'b0, 1'b0, 32'd0},
			{8'h01, 3'd0, 1'b1, 1'b0, 32'd0},
			{8'hFE, 3'd7, 1'b1, 1'b1, NO_TABLE_HASH}
		};

		repeat (8) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		// directed rows
		foreach (directed_rows[i])
			send_byte(directed_rows[i].key, directed_rows[i].htype, directed_rows[i].lst,
				$urandom_range(0, send_gap_max), directed_rows[i].known,
				directed_rows[i].hash);
		drain_pause();

		// random keys with idling on both sides
		while (bytes_sent < DIRECTED_ROWS + 700)
			send_random_key(16);
		drain_pause();

		// long receiver hold while short keys stream back to back
		send_gap_max = 0;
		hold_out = 1'b1;
		for (int i = 0; i < 40; i++)
			send_random_key(3);
		send_gap_max = 9;
		drain_pause();

		// no idling on either side
		send_gap_max = 0;
		recv_gap_max = 0;
		while (bytes_sent < DIRECTED_ROWS + 1100)
			send_random_key(16);
		send_gap_max = 9;
		recv_gap_max = 9;
		drain_pause();

		// idling again to the end
		while (bytes_sent < DIRECTED_ROWS + RANDOM_BYTES)
			send_random_key(16);
		in_valid <= 1'b0;

		wait (pending_hashes.size() == 0);
		repeat (DRAIN_CYCLES) @(posedge clk);

		$display("Sent %0d key bytes and checked %0d hashes over hash types 0-7,",
			bytes_sent, hashes_seen);
		$display("with random, absent and long stalls on both request and result sides.");
		if (fail_count == 0) begin
			$display("[crypt_table_string_hash] OK");
		end else begin
			$display("[crypt_table_string_hash] ERROR");
		end
		$finish;
	end

	// Watchdog
	initial begin
		#2_000_000;
		$display("[crypt_table_string_hash] ERROR");
		$finish;
	end

endmodule
